FILE: rtl/core/srde_pkg.sv
// srde_pkg: shared constants, register indexes and types of the signed radix digit emitter
// no dependencies; used by srde_front, srde_back and signed_radix_digit_emitter_unit
package srde_pkg;

  localparam int VALUE_WIDTH = 63;
  localparam int MAX_BASE    = 16;
  localparam int SYM_W       = 8;
  localparam int BASE_W      = 5;
  localparam int DIGIT_W     = $clog2(MAX_BASE);

  // digit store: one entry per digit, least significant first
  localparam int STORE_DEPTH = 64;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = STORE_AW + 1;

  // the divider walks the magnitude one byte per cycle, top byte first
  localparam int CHUNK_W     = 8;
  localparam int MAG_CHUNKS  = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int MAG_PAD_W   = MAG_CHUNKS * CHUNK_W;
  localparam int CHUNK_IDX_W = (MAG_CHUNKS > 1) ? $clog2(MAG_CHUNKS) : 1;

  localparam int JOBQ_DEPTH  = 2;
  localparam int JOBQ_AW     = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W  = $clog2(JOBQ_DEPTH + 1);

  localparam int OQ_DEPTH    = 4;
  localparam int OQ_AW       = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd2;

  localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
  localparam logic [SYM_W-1:0]  CH_MINUS   = 8'h2D;
  localparam logic [SYM_W-1:0]  CH_PLUS    = 8'h2B;

  typedef logic [MAX_BASE-1:0][SYM_W-1:0] sym_tab_t;

  typedef struct packed {
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } job_t;

  typedef struct packed {
    logic                busy;
    logic [OQ_CNT_W-1:0] oq_cnt;
  } back_stat_t;

endpackage

FILE: rtl/core/signed_radix_digit_emitter_unit.sv
// signed_radix_digit_emitter_unit: top level, configuration registers, front and back
// depends on srde_pkg, srde_front, srde_back (and srde_ram through srde_back)
//
//   port group   kind         handshake                payload
//   in_          queue push   in_push / in_full        in_value (63b signed)
//   out_         queue pop    out_empty / out_pop      out_char_code (8b), out_last_char
//   cfg_         write port   cfg_we                   cfg_index (2b), cfg_wdata (64b)
//
// per word: a load step, then per digit one divider step for each byte of the running quotient
// from its highest nonzero byte down to byte 0 (at most 8), then a minus sign for a negative
// value and then the characters; the byte-serial divider paces the first part and the single read
// port of the digit store the second
// rst_n is synchronous: queues empty, radix 10, all symbols zero
// in_full rises while the two-entry job queue is full; emission pauses while the four-word
// output queue has no room
module signed_radix_digit_emitter_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_push,
  output logic                                    in_full,
  input  logic signed [srde_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                    out_empty,
  input  logic                                    out_pop,
  output logic [srde_pkg::SYM_W-1:0]              out_char_code,
  output logic                                    out_last_char,
  input  logic                                    cfg_we,
  input  logic [srde_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [srde_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

  logic [srde_pkg::BASE_W-1:0]      base_size_r;
  logic [srde_pkg::CFG_DATA_W-1:0]  chars_low_r, chars_high_r;
  srde_pkg::sym_tab_t               symbols;
  logic                             job_vld, job_take;
  srde_pkg::job_t                   job;
  srde_pkg::back_stat_t             bstat;

  assign symbols = {chars_high_r, chars_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r  <= srde_pkg::BASE_RESET;
      chars_low_r  <= '0;
      chars_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srde_pkg::CFG_BASE_SIZE:  base_size_r  <= cfg_wdata[srde_pkg::BASE_W-1:0];
        srde_pkg::CFG_CHARS_LOW:  chars_low_r  <= cfg_wdata;
        srde_pkg::CFG_CHARS_HIGH: chars_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  srde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .value     (in_value),
    .base_size (base_size_r),
    .symbols   (symbols),
    .job_vld   (job_vld),
    .job       (job),
    .job_take  (job_take)
  );

  srde_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_vld   (job_vld),
    .job       (job),
    .job_take  (job_take),
    .base_size (base_size_r),
    .symbols   (symbols),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_char  (out_char_code),
    .out_last  (out_last_char),
    .stat      (bstat)
  );

  // output queue never overfills despite the read in flight
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.oq_cnt <= srde_pkg::OQ_CNT_W'(srde_pkg::OQ_DEPTH))
    else $error("output queue overfilled");

  // at most one word enters the output queue per cycle
  a_oq_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      ({1'b0, bstat.oq_cnt} <= {1'b0, $past(bstat.oq_cnt)} + 1'b1))
    else $error("output queue grew by more than one word");

  // empty flag agrees with the queue fill level
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_empty == (bstat.oq_cnt == '0))
    else $error("empty flag disagrees with output queue level");

  // an idle back end adds nothing to the output queue
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !bstat.busy |=> (bstat.oq_cnt <= $past(bstat.oq_cnt)))
    else $error("output queue grew while the back end was idle");

endmodule

FILE: rtl/core/srde_ram.sv
// srde_ram: generic single write port, single read port ram with registered read
// no dependencies
module srde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: rtl/core/srde_front.sv
// srde_front: accepts values, checks the alphabet, forms sign and magnitude, two-entry job queue
// depends on srde_pkg
module srde_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic signed [srde_pkg::VALUE_WIDTH-1:0] value,
  input  logic [srde_pkg::BASE_W-1:0]         base_size,
  input  srde_pkg::sym_tab_t                  symbols,
  output logic                                job_vld,
  output srde_pkg::job_t                      job,
  input  logic                                job_take
);

  srde_pkg::job_t                      jq_r [srde_pkg::JOBQ_DEPTH];
  logic [srde_pkg::JOBQ_AW-1:0]        wp_r, rp_r;
  logic [srde_pkg::JOBQ_CNT_W-1:0]     cnt_r;
  logic                                base_ok;
  logic [srde_pkg::VALUE_WIDTH-1:0]    vbits;
  srde_pkg::job_t                      new_job;
  logic                                enq, deq;

  // alphabet check: radix range, no sign symbols, no repeats among the first base_size
  always_comb begin
    base_ok = (base_size >= srde_pkg::BASE_W'(2)) &&
              (base_size <= srde_pkg::BASE_W'(srde_pkg::MAX_BASE));
    for (int i = 0; i < srde_pkg::MAX_BASE; i++) begin
      if (srde_pkg::BASE_W'(i) < base_size) begin
        if (symbols[i] == srde_pkg::CH_MINUS || symbols[i] == srde_pkg::CH_PLUS) begin
          base_ok = 1'b0;
        end
        for (int j = i + 1; j < srde_pkg::MAX_BASE; j++) begin
          if (srde_pkg::BASE_W'(j) < base_size && symbols[j] == symbols[i]) begin
            base_ok = 1'b0;
          end
        end
      end
    end
  end

  // magnitude as unsigned, so the most negative value needs no extra bit
  assign vbits       = value;
  assign new_job.neg = vbits[srde_pkg::VALUE_WIDTH-1];
  assign new_job.mag = new_job.neg ? srde_pkg::VALUE_WIDTH'(~vbits + 1'b1) : vbits;

  assign full    = (cnt_r == srde_pkg::JOBQ_CNT_W'(srde_pkg::JOBQ_DEPTH));
  assign job_vld = (cnt_r != '0);
  assign job     = jq_r[rp_r];

  // words for an invalid alphabet are taken and dropped
  assign enq = push && !full && base_ok;
  assign deq = job_vld && job_take;

  always_ff @(posedge clk) begin
    if (enq) begin
      jq_r[wp_r] <= new_job;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (enq) begin
        wp_r <= (wp_r == srde_pkg::JOBQ_AW'(srde_pkg::JOBQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (deq) begin
        rp_r <= (rp_r == srde_pkg::JOBQ_AW'(srde_pkg::JOBQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + srde_pkg::JOBQ_CNT_W'(enq) - srde_pkg::JOBQ_CNT_W'(deq);
    end
  end

endmodule

FILE: rtl/core/srde_back.sv
// srde_back: byte-serial radix divider, digit store, most-significant-first emission, output queue
// depends on srde_pkg and srde_ram
module srde_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_vld,
  input  srde_pkg::job_t                job,
  output logic                          job_take,
  input  logic [srde_pkg::BASE_W-1:0]   base_size,
  input  srde_pkg::sym_tab_t            symbols,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [srde_pkg::SYM_W-1:0]    out_char,
  output logic                          out_last,
  output srde_pkg::back_stat_t          stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t                              state_r, state_nxt;
  logic [srde_pkg::MAG_PAD_W-1:0]      q_r, q_nxt;
  logic [srde_pkg::DIGIT_W-1:0]        rem_r, rem_nxt;
  logic [srde_pkg::CHUNK_IDX_W-1:0]    ci_r, ci_nxt;
  logic [srde_pkg::COUNT_W-1:0]        dcnt_r, dcnt_nxt;
  logic [srde_pkg::COUNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                                neg_r, neg_nxt;
  logic                                rd_vld_r, rd_vld_nxt;
  logic                                rd_last_r, rd_last_nxt;

  logic [srde_pkg::SYM_W-1:0]          oq_char_r [srde_pkg::OQ_DEPTH];
  logic                                oq_last_r [srde_pkg::OQ_DEPTH];
  logic [srde_pkg::OQ_AW-1:0]          oq_wp_r, oq_rp_r;
  logic [srde_pkg::OQ_CNT_W-1:0]       oq_cnt_r;

  logic [srde_pkg::CHUNK_W-1:0]        chunk, qchunk;
  logic [srde_pkg::DIGIT_W:0]          part;
  logic [srde_pkg::DIGIT_W-1:0]        digit;
  logic [srde_pkg::MAG_PAD_W-1:0]      q_upd, q_load;
  logic                                ram_we;
  logic [srde_pkg::STORE_AW-1:0]       ram_raddr;
  logic [srde_pkg::DIGIT_W-1:0]        ram_rdata;
  logic                                space, sign_push, oq_push, oq_pop;
  logic [srde_pkg::SYM_W-1:0]          push_char;
  logic                                push_last;

  function automatic logic [srde_pkg::CHUNK_IDX_W-1:0] top_chunk(
    input logic [srde_pkg::MAG_PAD_W-1:0] q
  );
    logic [srde_pkg::CHUNK_IDX_W-1:0] idx;
    idx = '0;
    for (int c = 0; c < srde_pkg::MAG_CHUNKS; c++) begin
      if (q[c*srde_pkg::CHUNK_W +: srde_pkg::CHUNK_W] != '0) begin
        idx = srde_pkg::CHUNK_IDX_W'(c);
      end
    end
    return idx;
  endfunction

  // one byte of long division by the radix, remainder carried in rem_r
  always_comb begin
    chunk = q_r[ci_r*srde_pkg::CHUNK_W +: srde_pkg::CHUNK_W];
    part  = {1'b0, rem_r};
    for (int b = srde_pkg::CHUNK_W - 1; b >= 0; b--) begin
      part = {part[srde_pkg::DIGIT_W-1:0], chunk[b]};
      if (part >= base_size) begin
        part      = part - base_size;
        qchunk[b] = 1'b1;
      end else begin
        qchunk[b] = 1'b0;
      end
    end
    digit = part[srde_pkg::DIGIT_W-1:0];
    q_upd = q_r;
    q_upd[ci_r*srde_pkg::CHUNK_W +: srde_pkg::CHUNK_W] = qchunk;
  end

  assign q_load    = srde_pkg::MAG_PAD_W'(job.mag);
  assign ram_raddr = rd_idx_nxt[srde_pkg::STORE_AW-1:0];

  // room check counts the read still in flight
  assign space = (srde_pkg::OQ_CNT_W'(oq_cnt_r) + srde_pkg::OQ_CNT_W'(rd_vld_r)) <
                 srde_pkg::OQ_CNT_W'(srde_pkg::OQ_DEPTH);

  always_comb begin
    state_nxt   = state_r;
    q_nxt       = q_r;
    rem_nxt     = rem_r;
    ci_nxt      = ci_r;
    dcnt_nxt    = dcnt_r;
    rd_idx_nxt  = rd_idx_r;
    neg_nxt     = neg_r;
    rd_vld_nxt  = 1'b0;
    rd_last_nxt = 1'b0;
    job_take    = 1'b0;
    ram_we      = 1'b0;
    sign_push   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (job_vld) begin
          job_take  = 1'b1;
          q_nxt     = q_load;
          rem_nxt   = '0;
          ci_nxt    = top_chunk(q_load);
          dcnt_nxt  = '0;
          neg_nxt   = job.neg;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        q_nxt   = q_upd;
        rem_nxt = digit;
        if (ci_r != '0) begin
          ci_nxt = ci_r - 1'b1;
        end else begin
          ram_we   = 1'b1;
          dcnt_nxt = dcnt_r + 1'b1;
          if (q_upd == '0 ||
              dcnt_r == srde_pkg::COUNT_W'(srde_pkg::STORE_DEPTH - 1)) begin
            rd_idx_nxt = dcnt_r + 1'b1;
            state_nxt  = neg_r ? S_SIGN : S_EMIT;
          end else begin
            rem_nxt = '0;
            ci_nxt  = top_chunk(q_upd);
          end
        end
      end
      S_SIGN: begin
        if (space) begin
          sign_push = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (space) begin
          rd_idx_nxt  = rd_idx_r - 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (rd_idx_r == srde_pkg::COUNT_W'(1));
          if (rd_idx_r == srde_pkg::COUNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  srde_ram #(
    .WIDTH (srde_pkg::DIGIT_W),
    .DEPTH (srde_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dcnt_r[srde_pkg::STORE_AW-1:0]),
    .wdata (digit),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // the sign and a returning digit never arrive in the same cycle
  assign oq_push   = sign_push || rd_vld_r;
  assign push_char = rd_vld_r ? symbols[ram_rdata] : srde_pkg::CH_MINUS;
  assign push_last = rd_vld_r && rd_last_r;
  assign oq_pop    = out_pop && !out_empty;

  assign out_empty   = (oq_cnt_r == '0);
  assign out_char    = oq_char_r[oq_rp_r];
  assign out_last    = oq_last_r[oq_rp_r];
  assign stat.busy   = (state_r != S_IDLE) || rd_vld_r;
  assign stat.oq_cnt = oq_cnt_r;

  always_ff @(posedge clk) begin
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    ci_r      <= ci_nxt;
    dcnt_r    <= dcnt_nxt;
    rd_idx_r  <= rd_idx_nxt;
    neg_r     <= neg_nxt;
    rd_last_r <= rd_last_nxt;
    if (oq_push) begin
      oq_char_r[oq_wp_r] <= push_char;
      oq_last_r[oq_wp_r] <= push_last;
    end
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (oq_push) begin
        oq_wp_r <= (oq_wp_r == srde_pkg::OQ_AW'(srde_pkg::OQ_DEPTH - 1)) ? '0 : oq_wp_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rp_r <= (oq_rp_r == srde_pkg::OQ_AW'(srde_pkg::OQ_DEPTH - 1)) ? '0 : oq_rp_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + srde_pkg::OQ_CNT_W'(oq_push) - srde_pkg::OQ_CNT_W'(oq_pop);
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for signed_radix_digit_emitter_unit
// depends on srde_pkg and the emitter rtl; predicts every character word and checks them in order

module tb_top;

  localparam int SETTLE_CYCLES = 1200;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int IDLE_PCT      = 23;
  localparam int PHASE_ITEMS   = 23;
  localparam int RAND_PHASES   = 8;

  localparam logic [srde_pkg::CFG_IDX_W-1:0]   CFG_UNUSED = 2'd3;
  localparam logic [srde_pkg::VALUE_WIDTH-1:0] VAL_MAX    =
    {1'b0, {(srde_pkg::VALUE_WIDTH-1){1'b1}}};
  localparam logic [srde_pkg::VALUE_WIDTH-1:0] VAL_MIN    =
    {1'b1, {(srde_pkg::VALUE_WIDTH-1){1'b0}}};
  localparam logic [srde_pkg::CFG_DATA_W-1:0]  HEX_LO     = 64'h3736353433323130;
  localparam logic [srde_pkg::CFG_DATA_W-1:0]  HEX_HI     = 64'h4645444342413938;

  typedef struct packed {
    logic [srde_pkg::SYM_W-1:0] code;
    logic                       last;
  } char_word_t;

  logic                                    clk           = 1'b0;
  logic                                    rst_n         = 1'b0;
  logic                                    in_push       = 1'b0;
  logic                                    in_full;
  logic signed [srde_pkg::VALUE_WIDTH-1:0] in_value      = '0;
  logic                                    out_empty;
  logic                                    out_pop       = 1'b0;
  logic [srde_pkg::SYM_W-1:0]              out_char_code;
  logic                                    out_last_char;
  logic                                    cfg_we        = 1'b0;
  logic [srde_pkg::CFG_IDX_W-1:0]          cfg_index     = '0;
  logic [srde_pkg::CFG_DATA_W-1:0]         cfg_wdata     = '0;

  // shadow of the configuration registers
  logic [srde_pkg::BASE_W-1:0]     base_cfg = srde_pkg::BASE_RESET;
  logic [srde_pkg::CFG_DATA_W-1:0] sym_low  = '0;
  logic [srde_pkg::CFG_DATA_W-1:0] sym_high = '0;

  logic [srde_pkg::VALUE_WIDTH-1:0] value_queue [$];
  char_word_t                       char_queue [$];

  logic calm      = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   err_cnt   = 0;
  int   cycle_cnt = 0;

  signed_radix_digit_emitter_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_value      (in_value),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [srde_pkg::SYM_W-1:0] symbol_of(input int idx);
    logic [2*srde_pkg::CFG_DATA_W-1:0] both;
    both = {sym_high, sym_low};
    return both[idx*srde_pkg::SYM_W +: srde_pkg::SYM_W];
  endfunction

  // expected characters of one number under the current radix and alphabet
  function automatic void predict_chars(input logic [srde_pkg::VALUE_WIDTH-1:0] v);
    logic                             ok;
    logic                             neg;
    logic [srde_pkg::VALUE_WIDTH-1:0] mag;
    logic [srde_pkg::DIGIT_W-1:0]     digits [0:srde_pkg::STORE_DEPTH-1];
    int                               n;
    ok = (base_cfg > 1 && base_cfg <= srde_pkg::MAX_BASE);
    for (int i = 0; i < srde_pkg::MAX_BASE; i++) begin
      for (int j = 0; j < srde_pkg::MAX_BASE; j++) begin
        if (i < base_cfg && j < base_cfg) begin
          if (symbol_of(i) == srde_pkg::CH_PLUS || symbol_of(i) == srde_pkg::CH_MINUS) ok = 1'b0;
          if (j > i && symbol_of(i) == symbol_of(j)) ok = 1'b0;
        end
      end
    end
    if (!ok) return;
    neg = v[srde_pkg::VALUE_WIDTH-1];
    mag = neg ? -v : v;
    n = 0;
    do begin
      digits[n] = srde_pkg::DIGIT_W'(mag % base_cfg);
      mag = mag / base_cfg;
      n++;
    end while (mag != 0 && n < srde_pkg::STORE_DEPTH);
    if (neg) char_queue.push_back('{srde_pkg::CH_MINUS, 1'b0});
    for (int k = n - 1; k >= 0; k--)
      char_queue.push_back('{symbol_of(digits[k]), k == 0});
  endfunction

  task automatic write_reg(input logic [srde_pkg::CFG_IDX_W-1:0] idx,
                           input logic [srde_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      srde_pkg::CFG_BASE_SIZE:  base_cfg = data[srde_pkg::BASE_W-1:0];
      srde_pkg::CFG_CHARS_LOW:  sym_low  = data;
      srde_pkg::CFG_CHARS_HIGH: sym_high = data;
      default: ;
    endcase
  endtask

  // wait for every word to drain, then give a number with no output time to finish
  task automatic settle();
    do @(posedge clk);
    while (value_queue.size() != 0 || in_push || char_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin : drive_proc
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) predict_chars(in_value);
      if (in_push && in_full) begin
        // hold the word until taken
      end else if (value_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_push  <= 1'b1;
        in_value <= value_queue.pop_front();
      end else begin
        in_push  <= 1'b0;
        in_value <= srde_pkg::VALUE_WIDTH'({$urandom, $urandom});
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : watch_proc
    char_word_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (char_queue.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected word: code %h last %b", out_char_code, out_last_char);
        end else begin
          want = char_queue.pop_front();
          if (want.code !== out_char_code || want.last !== out_last_char) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: expected code %h last %b, got code %h last %b",
                       want.code, want.last, out_char_code, out_last_char);
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= calm || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stim_proc
    logic [srde_pkg::SYM_W-1:0]       alpha [0:srde_pkg::MAX_BASE-1];
    bit                               used [0:255];
    logic [srde_pkg::SYM_W-1:0]       sym;
    logic [srde_pkg::CFG_DATA_W-1:0]  lo;
    logic [srde_pkg::CFG_DATA_W-1:0]  hi;
    logic [srde_pkg::CFG_DATA_W-1:0]  data;
    logic [63:0]                      raw;
    logic [srde_pkg::VALUE_WIDTH-1:0] v;
    logic [srde_pkg::VALUE_WIDTH-1:0] pow;
    int                               radix;
    int                               k;
    bit                               spoil;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset alphabet is all zero bytes: repeated symbols, nothing comes out
    value_queue.push_back(VAL_MAX);
    value_queue.push_back('1);
    settle();

    write_reg(srde_pkg::CFG_CHARS_LOW, HEX_LO);
    write_reg(srde_pkg::CFG_CHARS_HIGH, HEX_HI);
    write_reg(srde_pkg::CFG_BASE_SIZE, 64'd10);
    write_reg(CFG_UNUSED, '1);
    value_queue.push_back('0);
    value_queue.push_back(1);
    value_queue.push_back('1);
    value_queue.push_back(10);
    value_queue.push_back(-srde_pkg::VALUE_WIDTH'(10));
    value_queue.push_back(12345);
    value_queue.push_back(VAL_MAX);
    value_queue.push_back(VAL_MIN);
    settle();

    write_reg(srde_pkg::CFG_BASE_SIZE, 64'd16);
    value_queue.push_back(VAL_MAX);
    value_queue.push_back(VAL_MIN);
    value_queue.push_back('0);
    value_queue.push_back('1);
    value_queue.push_back(srde_pkg::VALUE_WIDTH'(64'h0123456789ABCDEF));
    settle();

    write_reg(srde_pkg::CFG_BASE_SIZE, 64'd2);
    value_queue.push_back(VAL_MIN);
    value_queue.push_back(VAL_MAX);
    value_queue.push_back(5);
    settle();

    // radix too small
    write_reg(srde_pkg::CFG_BASE_SIZE, 64'd0);
    value_queue.push_back(7);
    settle();
    write_reg(srde_pkg::CFG_BASE_SIZE, 64'd1);
    value_queue.push_back(7);
    settle();

    // minus sign, plus sign and a repeated symbol inside the alphabet
    write_reg(srde_pkg::CFG_BASE_SIZE, 64'd10);
    write_reg(srde_pkg::CFG_CHARS_LOW, {HEX_LO[63:32], srde_pkg::CH_MINUS, HEX_LO[23:0]});
    value_queue.push_back(42);
    settle();
    write_reg(srde_pkg::CFG_CHARS_LOW, HEX_LO);
    write_reg(srde_pkg::CFG_CHARS_HIGH, {HEX_HI[63:16], srde_pkg::CH_PLUS, HEX_HI[7:0]});
    value_queue.push_back(42);
    settle();
    write_reg(srde_pkg::CFG_CHARS_HIGH, {HEX_HI[63:8], HEX_LO[63:56]});
    value_queue.push_back(42);
    settle();

    // a zero byte is an ordinary symbol
    write_reg(srde_pkg::CFG_CHARS_HIGH, HEX_HI);
    write_reg(srde_pkg::CFG_CHARS_LOW, {HEX_LO[63:24], 8'h62, 8'h61, 8'h00});
    write_reg(srde_pkg::CFG_BASE_SIZE, 64'd3);
    value_queue.push_back(-srde_pkg::VALUE_WIDTH'(5));
    value_queue.push_back('0);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(11))
        0:       radix = 2;
        1:       radix = srde_pkg::MAX_BASE;
        2:       radix = $urandom_range(1);
        default: radix = $urandom_range(2, srde_pkg::MAX_BASE);
      endcase
      spoil = radix >= 2 && $urandom_range(5) == 0;
      if (p == 0) begin
        radix = 10;
        spoil = 1'b0;
      end
      used = '{default: 1'b0};
      for (int i = 0; i < srde_pkg::MAX_BASE; i++) begin
        do sym = srde_pkg::SYM_W'($urandom_range(255));
        while (i < radix &&
               (sym == srde_pkg::CH_PLUS || sym == srde_pkg::CH_MINUS || used[sym]));
        used[sym] = 1'b1;
        alpha[i] = sym;
      end
      if (spoil) begin
        k = $urandom_range(radix - 1);
        case ($urandom_range(2))
          0:       alpha[k] = srde_pkg::CH_PLUS;
          1:       alpha[k] = srde_pkg::CH_MINUS;
          default: alpha[radix-1] = alpha[$urandom_range(radix - 2)];
        endcase
      end
      for (int i = 0; i < 8; i++) begin
        lo[i*srde_pkg::SYM_W +: srde_pkg::SYM_W] = alpha[i];
        hi[i*srde_pkg::SYM_W +: srde_pkg::SYM_W] = alpha[i+8];
      end
      write_reg(srde_pkg::CFG_CHARS_LOW, lo);
      write_reg(srde_pkg::CFG_CHARS_HIGH, hi);
      data = {$urandom, $urandom};
      data[srde_pkg::BASE_W-1:0] = srde_pkg::BASE_W'(radix);
      write_reg(srde_pkg::CFG_BASE_SIZE, data);

      // receiver stalls long in the first phase while the sender keeps pushing
      if (p == 0) hold_req <= 1'b1;
      calm <= (p == 3);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        raw = {$urandom, $urandom};
        case ($urandom_range(9))
          0, 1, 2, 3: v = raw[srde_pkg::VALUE_WIDTH-1:0];
          4:          v = $urandom_range(999);
          5:          v = -srde_pkg::VALUE_WIDTH'($urandom_range(1, 999));
          6:          v = srde_pkg::VALUE_WIDTH'(raw >> $urandom_range(1, srde_pkg::VALUE_WIDTH));
          7:          v = -srde_pkg::VALUE_WIDTH'(raw >> $urandom_range(1, srde_pkg::VALUE_WIDTH));
          8: begin
            case (raw[1:0])
              2'd0:    v = VAL_MAX;
              2'd1:    v = VAL_MIN;
              2'd2:    v = '0;
              default: v = '1;
            endcase
          end
          default: begin
            // around a power of the radix, where the digit count steps
            pow = 1;
            repeat ($urandom_range(1, 20))
              if (pow <= VAL_MAX / srde_pkg::MAX_BASE) pow = pow * base_cfg;
            v = pow - $urandom_range(1);
            if (raw[0]) v = -v;
          end
        endcase
        value_queue.push_back(v);
      end
      settle();
      calm <= 1'b0;
    end

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
